FILE: src/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg: shared definitions for the integer matrix multiplier
// Types, widths, register indexes and sequencer states used by every module.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM_DEFAULT = 8;
  localparam int DATA_W          = 32;
  localparam int REG_W           = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int ROW_W           = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [REG_W-1:0] REG_RESET = 4'd8;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  // Tags that travel with one pair of operand reads down the MAC pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } issue_t;

endpackage

FILE: src/integer_matrix_multiply.sv
// Loading: one element request is taken per cycle while the block is idle.
// Compute: after the request that completes both matrices, each result element
//   is computed in turn on the single shared multiply-accumulate unit.
// Reset: synchronous, active high; registers go to 8, load counts to zero.
// ----------------------------------------------------------------------------
// integer_matrix_multiply: sequential signed integer matrix multiplier
// Loads A then B element by element, then computes C = A x B modulo 2^32
// and streams C out in row-major order with a last mark.
// ----------------------------------------------------------------------------
module integer_matrix_multiply #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_en,
  input  logic [imm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imm_pkg::REG_W-1:0]         cfg_data,
  // Input element channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic signed [imm_pkg::DATA_W-1:0] elem,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [imm_pkg::ROW_W-1:0]         row,
  output logic [imm_pkg::ROW_W-1:0]         col,
  output logic signed [imm_pkg::DATA_W-1:0] product,
  output logic                              last
);

  // Store geometry. A one-entry store still gets a one-bit address.
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [imm_pkg::REG_W-1:0] rows_a, inner_dim, cols_b;
  logic [DIM_W-1:0]          nr, nk, nc;

  logic                       wr_a_en, wr_b_en;
  logic [ADDR_W-1:0]          wr_a_addr, wr_b_addr, rd_a_addr, rd_b_addr;
  logic [imm_pkg::DATA_W-1:0] a_data, b_data, mac_acc, prod_out;
  imm_pkg::issue_t            issue;
  logic                       mac_done;

  // Configuration registers. A write to an unused index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= imm_pkg::REG_RESET;
      inner_dim <= imm_pkg::REG_RESET;
      cols_b    <= imm_pkg::REG_RESET;
    end else if (cfg_en) begin
      unique case (cfg_index)
        imm_pkg::REG_ROWS_A:    rows_a    <= cfg_data;
        imm_pkg::REG_INNER_DIM: inner_dim <= cfg_data;
        imm_pkg::REG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A size of zero is treated as one, and anything above the largest
  // supported dimension is clamped to it.
  function automatic logic [DIM_W-1:0] eff_size(input logic [imm_pkg::REG_W-1:0] v);
    logic [DIM_W-1:0] r;
    priority if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > imm_pkg::REG_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign nr = eff_size(rows_a);
  assign nk = eff_size(inner_dim);
  assign nc = eff_size(cols_b);

  // The sequencer owns the load counts, the index walk and the result
  // register; the stores are written only while idle and read only while
  // computing, so each needs just one write and one read port.
  imm_ctrl #(
    .DIM_W   (DIM_W),
    .IDX_W   (IDX_W),
    .ADDR_W  (ADDR_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .nr        (nr),
    .nk        (nk),
    .nc        (nc),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .wr_a_en   (wr_a_en),
    .wr_b_en   (wr_b_en),
    .wr_a_addr (wr_a_addr),
    .wr_b_addr (wr_b_addr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .issue     (issue),
    .mac_done  (mac_done),
    .mac_acc   (mac_acc),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row       (row),
    .col       (col),
    .product   (prod_out),
    .last      (last)
  );

  assign product = prod_out;

  imm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a_en),
    .wr_addr (wr_a_addr),
    .wr_data (elem),
    .rd_en   (issue.valid),
    .rd_addr (rd_a_addr),
    .rd_data (a_data)
  );

  imm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b_en),
    .wr_addr (wr_b_addr),
    .wr_data (elem),
    .rd_en   (issue.valid),
    .rd_addr (rd_b_addr),
    .rd_data (b_data)
  );

  // One multiply-accumulate unit serves every element of the result; it reports
  // done through the tag registers s1 and s2 and a done register after the last pair.
  imm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .a_data (a_data),
    .b_data (b_data),
    .done   (mac_done),
    .acc    (mac_acc)
  );

endmodule

FILE: src/imm_store.sv
// ----------------------------------------------------------------------------
// imm_store: element store for one matrix
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module imm_store #(
  parameter int DEPTH  = imm_pkg::MAX_DIM_DEFAULT * imm_pkg::MAX_DIM_DEFAULT,
  parameter int ADDR_W = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [imm_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [imm_pkg::DATA_W-1:0] rd_data
);

  logic [imm_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/imm_mac.sv
// ----------------------------------------------------------------------------
// imm_mac: shared multiply-accumulate unit
// Registered multiply of two operands, then a wrapping 32-bit accumulate.
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  imm_pkg::issue_t            issue,
  input  logic [imm_pkg::DATA_W-1:0] a_data,
  input  logic [imm_pkg::DATA_W-1:0] b_data,
  output logic                       done,
  output logic [imm_pkg::DATA_W-1:0] acc
);

  // Tags line up with the store read data, which lands in the cycle after issue.
  imm_pkg::issue_t            s1;
  imm_pkg::issue_t            s2;
  logic [imm_pkg::DATA_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= '0;
      s2   <= '0;
      done <= 1'b0;
    end else begin
      s1   <= issue;
      s2   <= s1;
      done <= s2.valid && s2.last;
    end
  end

  // Only the low word of the product matters for a sum taken modulo 2^32.
  always_ff @(posedge clk) begin
    if (s1.valid) begin
      prod <= imm_pkg::DATA_W'(a_data * b_data);
    end
  end

  always_ff @(posedge clk) begin
    if (s2.valid) begin
      if (s2.first) begin
        acc <= prod;
      end else begin
        acc <= acc + prod;
      end
    end
  end

endmodule

FILE: src/imm_ctrl.sv
// ----------------------------------------------------------------------------
// imm_ctrl: load counters, compute sequencer and result register
// Counts incoming elements, walks rows, columns and the inner index of the
// product, and holds each finished element until it is taken.
// ----------------------------------------------------------------------------
module imm_ctrl #(
  parameter int DIM_W   = 4,
  parameter int IDX_W   = 3,
  parameter int ADDR_W  = 6,
  parameter int CNT_W   = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [DIM_W-1:0]           nr,
  input  logic [DIM_W-1:0]           nk,
  input  logic [DIM_W-1:0]           nc,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  output logic                       wr_a_en,
  output logic                       wr_b_en,
  output logic [ADDR_W-1:0]          wr_a_addr,
  output logic [ADDR_W-1:0]          wr_b_addr,
  output logic [ADDR_W-1:0]          rd_a_addr,
  output logic [ADDR_W-1:0]          rd_b_addr,
  output imm_pkg::issue_t            issue,
  input  logic                       mac_done,
  input  logic [imm_pkg::DATA_W-1:0] mac_acc,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [imm_pkg::ROW_W-1:0]  row,
  output logic [imm_pkg::ROW_W-1:0]  col,
  output logic [imm_pkg::DATA_W-1:0] product,
  output logic                       last
);

  imm_pkg::state_t state, state_next;

  logic [CNT_W-1:0]  count_a, count_b;
  logic [CNT_W-1:0]  count_a_next, count_b_next;
  logic [CNT_W-1:0]  size_a, size_b;
  logic [IDX_W-1:0]  i, j, k;
  logic [ADDR_W-1:0] a_base, a_addr, b_addr;

  logic accept, take_a, take_b, complete;
  logic elem_last, row_last, col_last, out_free, load_out, final_elem;

  assign size_a = CNT_W'(nr) * CNT_W'(nk);
  assign size_b = CNT_W'(nk) * CNT_W'(nc);

  assign accept   = in_valid && !in_stall;
  assign take_a   = accept && !func && (count_a < size_a);
  assign take_b   = accept &&  func && (count_b < size_b);
  assign count_a_next = count_a + CNT_W'(take_a);
  assign count_b_next = count_b + CNT_W'(take_b);
  assign complete = accept && (count_a_next >= size_a) && (count_b_next >= size_b);

  assign elem_last  = DIM_W'(k) == nk - DIM_W'(1);
  assign row_last   = DIM_W'(i) == nr - DIM_W'(1);
  assign col_last   = DIM_W'(j) == nc - DIM_W'(1);
  assign final_elem = row_last && col_last;
  assign out_free   = !out_valid || !out_stall;

  assign wr_a_en   = take_a;
  assign wr_b_en   = take_b;
  assign wr_a_addr = count_a[ADDR_W-1:0];
  assign wr_b_addr = count_b[ADDR_W-1:0];
  assign rd_a_addr = a_addr;
  assign rd_b_addr = b_addr;

  always_comb begin
    state_next = state;
    unique case (state)
      imm_pkg::ST_IDLE: begin
        if (complete) state_next = imm_pkg::ST_ISSUE;
      end
      imm_pkg::ST_ISSUE: begin
        if (elem_last) state_next = imm_pkg::ST_WAIT;
      end
      imm_pkg::ST_WAIT: begin
        if (mac_done) state_next = imm_pkg::ST_OUT;
      end
      imm_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = final_elem ? imm_pkg::ST_IDLE : imm_pkg::ST_ISSUE;
        end
      end
      default: state_next = imm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != imm_pkg::ST_IDLE);
    issue.valid = (state == imm_pkg::ST_ISSUE);
    issue.first = (k == '0);
    issue.last  = elem_last;
    load_out    = (state == imm_pkg::ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load counts; cleared once the final element of the result is loaded into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
    end else if (load_out && final_elem) begin
      count_a <= '0;
      count_b <= '0;
    end else begin
      count_a <= count_a_next;
      count_b <= count_b_next;
    end
  end

  // Index walk. The row of A starts at i*nk and steps by one; the column of
  // B starts at j and steps by nc.
  always_ff @(posedge clk) begin
    if (rst || complete) begin
      i      <= '0;
      j      <= '0;
      k      <= '0;
      a_base <= '0;
      a_addr <= '0;
      b_addr <= '0;
    end else if (issue.valid) begin
      k      <= elem_last ? '0 : k + IDX_W'(1);
      a_addr <= a_addr + ADDR_W'(1);
      b_addr <= b_addr + ADDR_W'(nc);
    end else if (load_out) begin
      if (col_last) begin
        i      <= i + IDX_W'(1);
        j      <= '0;
        a_base <= a_base + ADDR_W'(nk);
        a_addr <= a_base + ADDR_W'(nk);
        b_addr <= '0;
      end else begin
        j      <= j + IDX_W'(1);
        a_addr <= a_base;
        b_addr <= ADDR_W'(j) + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      row     <= imm_pkg::ROW_W'(i);
      col     <= imm_pkg::ROW_W'(j);
      product <= mac_acc;
      last    <= final_elem;
    end
  end

endmodule

FILE: tb/integer_matrix_multiply_tb.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_tb: self-checking bench for the matrix multiplier
// Loads pairs of matrices under many size settings and predicts each element
// of the product. The streamed result elements are then compared in order,
// while both channels idle at random, except in the last, full-rate stage.
// ----------------------------------------------------------------------------

// Selects which matrix an element request feeds.
typedef enum bit {
  LOAD_A = 1'b0,
  LOAD_B = 1'b1
} load_sel_t;

typedef struct packed {
  logic [imm_pkg::ROW_W-1:0]  row;
  logic [imm_pkg::ROW_W-1:0]  col;
  logic [imm_pkg::DATA_W-1:0] product;
  logic                       last;
} mat_result_t;

// Mirrors the size registers and both element stores. It computes the
// product as soon as both matrices are complete, and it holds the result
// elements that have not come out yet.
class product_tracker;
  logic [imm_pkg::REG_W-1:0]  size_reg [3];
  logic [imm_pkg::DATA_W-1:0] a_store [imm_pkg::MAX_DIM_DEFAULT*imm_pkg::MAX_DIM_DEFAULT];
  logic [imm_pkg::DATA_W-1:0] b_store [imm_pkg::MAX_DIM_DEFAULT*imm_pkg::MAX_DIM_DEFAULT];
  int unsigned a_count;
  int unsigned b_count;
  mat_result_t expected_elems [$];
  int errors;

  function new();
    foreach (size_reg[i]) size_reg[i] = imm_pkg::REG_RESET;
    a_count = 0;
    b_count = 0;
    errors  = 0;
  endfunction

  // A zero size acts as one, and anything above the maximum acts as the maximum.
  function int unsigned usable_size(logic [imm_pkg::REG_W-1:0] value);
    if (value == 0) return 1;
    if (value > imm_pkg::MAX_DIM_DEFAULT) return imm_pkg::MAX_DIM_DEFAULT;
    return 32'(value);
  endfunction

  function void set_reg(logic [imm_pkg::CFG_IDX_W-1:0] idx, logic [imm_pkg::REG_W-1:0] value);
    size_reg[idx] = value;
  endfunction

  function int pending();
    return expected_elems.size();
  endfunction

  function void note_request(load_sel_t sel, logic [imm_pkg::DATA_W-1:0] value);
    int unsigned nr, nk, nc, i, j, k;
    logic [imm_pkg::DATA_W-1:0] acc;
    mat_result_t elem_c;
    nr = usable_size(size_reg[imm_pkg::REG_ROWS_A]);
    nk = usable_size(size_reg[imm_pkg::REG_INNER_DIM]);
    nc = usable_size(size_reg[imm_pkg::REG_COLS_B]);
    // An element for a matrix that is already full is dropped.
    if (sel == LOAD_A) begin
      if (a_count < nr * nk) begin
        a_store[a_count] = value;
        a_count++;
      end
    end else begin
      if (b_count < nk * nc) begin
        b_store[b_count] = value;
        b_count++;
      end
    end
    if (a_count < nr * nk || b_count < nk * nc) return;
    for (i = 0; i < nr; i++) begin
      for (j = 0; j < nc; j++) begin
        acc = '0;
        for (k = 0; k < nk; k++) acc = acc + a_store[i*nk + k] * b_store[k*nc + j];
        elem_c.row     = i[imm_pkg::ROW_W-1:0];
        elem_c.col     = j[imm_pkg::ROW_W-1:0];
        elem_c.product = acc;
        elem_c.last    = (i == nr - 1) && (j == nc - 1);
        expected_elems.push_back(elem_c);
      end
    end
    a_count = 0;
    b_count = 0;
  endfunction

  function void check_result(mat_result_t got);
    mat_result_t want;
    if (expected_elems.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: row %0d col %0d product %0d last %0d",
                 got.row, got.col, $signed(got.product), got.last);
      return;
    end
    want = expected_elems.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected row %0d col %0d product %0d last %0d,",
                 want.row, want.col, $signed(want.product), want.last,
                 " got row %0d col %0d product %0d last %0d",
                 got.row, got.col, $signed(got.product), got.last);
    end
  endfunction
endclass

module integer_matrix_multiply_tb;

  localparam int RESET_CYCLES   = 11;
  // Quiet time after the last result before the sizes may change; it covers any
  // element still in the pipeline.
  localparam int SETTLE_CYCLES  = 16;
  // The limit must outlast the compute of a full 8x8x8 product, and stalls of
  // the receiver stretch that further, so the limit is set well above it.
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int RANDOM_ITEMS   = 300;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              cfg_en    = 1'b0;
  logic [imm_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [imm_pkg::REG_W-1:0]         cfg_data  = '0;
  logic                              in_valid  = 1'b0;
  logic                              in_stall;
  logic                              func      = 1'b0;
  logic signed [imm_pkg::DATA_W-1:0] elem      = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [imm_pkg::ROW_W-1:0]         row;
  logic [imm_pkg::ROW_W-1:0]         col;
  logic signed [imm_pkg::DATA_W-1:0] product;
  logic                              last;

  // Chance, in percent, that a side idles in a given cycle.
  int send_idle_pct = 31;
  int recv_idle_pct = 82;
  int quiet_cycles  = 0;
  int loaded_items  = 0;

  product_tracker board = new();

  integer_matrix_multiply dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .elem      (elem),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row       (row),
    .col       (col),
    .product   (product),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver decides its stall one cycle at a time, at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Both channels are sampled at the rising edge, where a request is taken.
  // Accepted inputs feed the predictor, and accepted results are checked
  // against the oldest expected element.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_request(load_sel_t'(func), elem);
    if (!rst && out_valid && !out_stall) board.check_result({row, col, product, last});
  end

  // The watchdog counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // One register write. The enable drops in the cycle after it rises, and the task
  // returns only after it has dropped, so calls back to back never raise and lower the
  // enable in the same step.
  task automatic write_size(logic [imm_pkg::CFG_IDX_W-1:0] idx,
                            logic [imm_pkg::REG_W-1:0] value);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_en <= 1'b0;
    @(negedge clk);
    board.set_reg(idx, value);
  endtask

  task automatic set_sizes(logic [imm_pkg::REG_W-1:0] nr,
                           logic [imm_pkg::REG_W-1:0] nk,
                           logic [imm_pkg::REG_W-1:0] nc);
    write_size(imm_pkg::REG_ROWS_A, nr);
    write_size(imm_pkg::REG_INNER_DIM, nk);
    write_size(imm_pkg::REG_COLS_B, nc);
  endtask

  // Called on a falling edge. The sender may first idle for a random number
  // of cycles. It then offers the request and holds it until it is taken.
  // Valid stays high on return, so that the next request can follow directly.
  task automatic send_elem(load_sel_t sel, logic [imm_pkg::DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= sel;
    elem     <= value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Waits until every expected element is out and the block has gone quiet.
  // Only then is it safe to touch the size registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A mix of full-range random values, small signed values and the extremes
  // that stress the wrap of the products and of the sums.
  function automatic logic [imm_pkg::DATA_W-1:0] pick_value();
    int small_val;
    small_val = $urandom_range(16);
    unique case ($urandom_range(3))
      0: begin
        unique case ($urandom_range(4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          3:       return 32'h0000_0000;
          default: return 32'h0000_0001;
        endcase
      end
      1:       return 32'(small_val - 8);
      default: return $urandom;
    endcase
  endfunction

  // Mostly small sizes keep the product short. Now and then a raw register
  // value from the whole 4-bit range exercises the clamping of sizes.
  function automatic logic [imm_pkg::REG_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return imm_pkg::REG_W'($urandom_range(4, 1));
    if (roll < 85) return imm_pkg::REG_W'($urandom_range(8, 5));
    return imm_pkg::REG_W'($urandom_range(15));
  endfunction

  // Loads one full pair of matrices under the current sizes. Most pairs come
  // as A then B. Others interleave the two at random, and a few slip in
  // elements for a matrix that is already full, which the block must drop.
  task automatic load_pair();
    int unsigned size_a, size_b, got_a, got_b;
    int style;
    load_sel_t sel;
    size_a = board.usable_size(board.size_reg[imm_pkg::REG_ROWS_A]) *
             board.usable_size(board.size_reg[imm_pkg::REG_INNER_DIM]);
    size_b = board.usable_size(board.size_reg[imm_pkg::REG_INNER_DIM]) *
             board.usable_size(board.size_reg[imm_pkg::REG_COLS_B]);
    got_a  = 0;
    got_b  = 0;
    style  = $urandom_range(99);
    while (got_a < size_a || got_b < size_b) begin
      if (style >= 90 && $urandom_range(3) == 0 && (got_a == size_a || got_b == size_b)) begin
        send_elem(got_a == size_a ? LOAD_A : LOAD_B, pick_value());
      end else begin
        if (got_a == size_a) sel = LOAD_B;
        else if (got_b == size_b) sel = LOAD_A;
        else if (style < 60) sel = LOAD_A;
        else sel = load_sel_t'($urandom_range(1));
        send_elem(sel, pick_value());
        if (sel == LOAD_A) got_a++;
        else got_b++;
        loaded_items++;
      end
    end
  endtask

  initial begin
    int n;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Smallest product with the largest positive operands: the square wraps to one.
    set_sizes(4'd1, 4'd1, 4'd1);
    send_elem(LOAD_A, 32'h7FFF_FFFF);
    send_elem(LOAD_B, 32'h7FFF_FFFF);
    drain();

    // All sizes zero act as one. The most negative value times minus one wraps
    // back to itself.
    set_sizes(4'd0, 4'd0, 4'd0);
    send_elem(LOAD_A, 32'h8000_0000);
    send_elem(LOAD_B, 32'hFFFF_FFFF);
    drain();

    // Outer product of two 2-element vectors with the extreme values.
    set_sizes(4'd2, 4'd1, 4'd2);
    send_elem(LOAD_A, 32'hFFFF_FFFF);
    send_elem(LOAD_A, 32'h8000_0000);
    send_elem(LOAD_B, 32'h7FFF_FFFF);
    send_elem(LOAD_B, 32'h0000_0001);
    drain();

    // A row count above the maximum acts as eight and reaches every row index.
    set_sizes(4'd15, 4'd1, 4'd1);
    for (n = 0; n < 8; n++) send_elem(LOAD_A, 32'(n * 1000 - 3500));
    send_elem(LOAD_B, 32'hFFFF_FFFE);
    drain();

    // Shrinking a size in the middle of a load. With A full and half of B
    // loaded, an extra A element is dropped. Narrowing B to one column then
    // makes the loaded part cover it, and the next request, itself an extra
    // element, starts the product.
    set_sizes(4'd2, 4'd2, 4'd2);
    send_elem(LOAD_A, 32'h0000_0003);
    send_elem(LOAD_A, 32'hFFFF_FFFB);
    send_elem(LOAD_A, 32'h8000_0000);
    send_elem(LOAD_A, 32'h7FFF_FFFF);
    send_elem(LOAD_B, 32'h0000_0007);
    send_elem(LOAD_B, 32'hFFFF_FFFF);
    send_elem(LOAD_A, 32'h1234_5678);
    drain();
    write_size(imm_pkg::REG_COLS_B, 4'd1);
    send_elem(LOAD_B, 32'h0BAD_F00D);
    drain();

    // Random part. The idle pattern moves through three stages: a slow
    // receiver, then a slow sender, then both at full rate.
    while (loaded_items < RANDOM_ITEMS) begin
      if (loaded_items >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (loaded_items >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 31;
      end
      drain();
      set_sizes(pick_size(), pick_size(), pick_size());
      load_pair();
    end
    drain();

    if (board.errors == 0 && board.pending() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
